FILE: hw/rtl/tspl_pkg.sv
package tspl_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int KEY_BYTES = 16;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int LINK_W = $clog2(SLOT_COUNT + 1);
    localparam int KEY_W = 64;

    localparam logic [LINK_W-1:0] NULL_SLOT = LINK_W'(SLOT_COUNT);

    localparam int LOW_KEY_BITS = (KEY_BYTES - 8) * 8;
    localparam logic [KEY_W-1:0] LOW_KEY_MASK =
        (LOW_KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
        (LOW_KEY_BITS == 0) ? {KEY_W{1'b0}} :
        ~((KEY_W'(1) << (KEY_W - LOW_KEY_BITS)) - KEY_W'(1));

    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_FREE = 3'd1;
    localparam logic [2:0] ACT_INSERT = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_FIND = 3'd4;
    localparam logic [2:0] ACT_INIT = 3'd5;

    localparam logic [1:0] STS_OK = 2'd0;
    localparam logic [1:0] STS_MISS = 2'd1;
    localparam logic [1:0] STS_REFUSED = 2'd2;

    localparam logic [1:0] COND_FREE = 2'd0;
    localparam logic [1:0] COND_ALLOC = 2'd1;
    localparam logic [1:0] COND_ACTIVE = 2'd2;

    typedef struct packed {
        logic              wr;
        logic              clr;
        logic              clr_all;
        logic [SLOT_W-1:0] addr;
    } key_ctrl_t;

endpackage

FILE: hw/rtl/tspl_key_store.sv
module tspl_key_store
    import tspl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  key_ctrl_t         ctrl,
    input  logic [KEY_W-1:0]  wr_high,
    input  logic [KEY_W-1:0]  wr_low,
    input  logic [SLOT_W-1:0] rd_addr,
    input  logic [KEY_W-1:0]  cmp_high,
    input  logic [KEY_W-1:0]  cmp_low,
    output logic              hit
);

    logic [KEY_W-1:0]      high_reg [SLOT_COUNT];
    logic [KEY_W-1:0]      low_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [KEY_W-1:0]      rd_high;
    logic [KEY_W-1:0]      rd_low;

    // An entry that is not valid reads as the cleared ID of all zeros.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clr_all) begin
            valid_reg <= '0;
        end else if (ctrl.wr) begin
            valid_reg[ctrl.addr] <= 1'b1;
        end else if (ctrl.clr) begin
            valid_reg[ctrl.addr] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            high_reg[ctrl.addr] <= wr_high;
            low_reg[ctrl.addr] <= wr_low;
        end
    end

    assign rd_high = valid_reg[rd_addr] ? high_reg[rd_addr] : '0;
    assign rd_low = valid_reg[rd_addr] ? low_reg[rd_addr] : '0;
    assign hit = (rd_high == cmp_high) && ((rd_low & LOW_KEY_MASK) == cmp_low);

endmodule

FILE: hw/rtl/transaction_slot_pool_lookup_top.sv
// Slot pool with ID lookup. Each input word carries one action (allocate, free, insert,
// remove, find or reinitialize) and produces exactly one result word with a status and a
// slot index. Allocate, free, insert, reinitialize, a refused word and a remove of the list
// head pass from acceptance through the execute state to the result register; find and an
// accepted remove of any other slot walk the active list one slot per cycle through the
// single link and ID read port, visiting at most SLOT_COUNT slots. The block accepts one
// word at a time and is ready again once the result has been moved into the output register.
module transaction_slot_pool_lookup_top
    import tspl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[2:0], slot_index[6:3], key_high[70:7], key_low[134:71], zero fill.
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], result_index[5:2], zero fill.
    output logic [7:0]   m_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_FIND = 3'd2;
    localparam logic [2:0] ST_UNLINK = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        act_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [KEY_W-1:0]  kh_reg, kl_reg;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] cnt_reg, cnt_next;
    logic [LINK_W-1:0] succ_reg, succ_next;
    logic [1:0]        status_reg, status_next;
    logic [SLOT_W-1:0] result_reg, result_next;
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [SLOT_W-1:0] m_result_reg;

    logic [LINK_W-1:0] free_link_reg [SLOT_COUNT];
    logic [LINK_W-1:0] active_link_reg [SLOT_COUNT];
    logic [1:0]        cond_reg [SLOT_COUNT];
    logic [LINK_W-1:0] free_top_reg, free_top_next;
    logic [LINK_W-1:0] head_reg, head_next;

    logic              init_en;
    logic              fl_we;
    logic [SLOT_W-1:0] fl_addr;
    logic [LINK_W-1:0] fl_data;
    logic              al_we;
    logic [SLOT_W-1:0] al_addr;
    logic [LINK_W-1:0] al_data;
    logic              al_clr;
    logic              cond_we;
    logic [SLOT_W-1:0] cond_addr;
    logic [1:0]        cond_data;

    logic              accept;
    logic              idx_ok;
    logic              cur_null;
    logic [SLOT_W-1:0] cur_idx;
    logic [SLOT_W-1:0] top_idx;
    logic [SLOT_W-1:0] al_rd_addr;
    logic [LINK_W-1:0] al_rd;
    logic              key_hit;
    key_ctrl_t         key_ctrl;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign idx_ok = ({1'b0, idx_reg} < LINK_W'(SLOT_COUNT));
    assign cur_null = (cur_reg >= LINK_W'(SLOT_COUNT)) || (cnt_reg == LINK_W'(SLOT_COUNT));
    assign cur_idx = cur_reg[SLOT_W-1:0];
    assign top_idx = free_top_reg[SLOT_W-1:0];
    assign al_rd_addr = (state_reg == ST_EXEC) ? idx_reg : cur_idx;
    assign al_rd = active_link_reg[al_rd_addr];

    tspl_key_store u_key_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (key_ctrl),
        .wr_high  (kh_reg),
        .wr_low   (kl_reg),
        .rd_addr  (cur_idx),
        .cmp_high (kh_reg),
        .cmp_low  (kl_reg),
        .hit      (key_hit)
    );

    always_comb begin
        state_next = state_reg;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        succ_next = succ_reg;
        status_next = status_reg;
        result_next = result_reg;
        free_top_next = free_top_reg;
        head_next = head_reg;
        init_en = 1'b0;
        fl_we = 1'b0;
        fl_addr = idx_reg;
        fl_data = NULL_SLOT;
        al_we = 1'b0;
        al_addr = cur_idx;
        al_data = NULL_SLOT;
        al_clr = 1'b0;
        cond_we = 1'b0;
        cond_addr = idx_reg;
        cond_data = COND_FREE;
        key_ctrl = '{wr: 1'b0, clr: 1'b0, clr_all: 1'b0, addr: idx_reg};
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                status_next = STS_OK;
                result_next = '0;
                state_next = ST_RESP;
                case (act_reg)
                    ACT_ALLOC: begin
                        if (free_top_reg >= LINK_W'(SLOT_COUNT)) begin
                            status_next = STS_MISS;
                        end else begin
                            free_top_next = free_link_reg[top_idx];
                            fl_we = 1'b1;
                            fl_addr = top_idx;
                            fl_data = NULL_SLOT;
                            cond_we = 1'b1;
                            cond_addr = top_idx;
                            cond_data = COND_ALLOC;
                            result_next = top_idx;
                        end
                    end
                    ACT_FREE: begin
                        if (!idx_ok || cond_reg[idx_reg] != COND_ALLOC) begin
                            status_next = STS_REFUSED;
                        end else begin
                            key_ctrl.clr = 1'b1;
                            al_clr = 1'b1;
                            fl_we = 1'b1;
                            fl_data = free_top_reg;
                            free_top_next = {1'b0, idx_reg};
                            cond_we = 1'b1;
                            cond_data = COND_FREE;
                        end
                    end
                    ACT_INSERT: begin
                        if (!idx_ok || cond_reg[idx_reg] != COND_ALLOC) begin
                            status_next = STS_REFUSED;
                        end else begin
                            key_ctrl.wr = 1'b1;
                            al_we = 1'b1;
                            al_addr = idx_reg;
                            al_data = head_reg;
                            head_next = {1'b0, idx_reg};
                            cond_we = 1'b1;
                            cond_data = COND_ACTIVE;
                        end
                    end
                    ACT_REMOVE: begin
                        if (!idx_ok || cond_reg[idx_reg] != COND_ACTIVE) begin
                            status_next = STS_REFUSED;
                        end else begin
                            cond_we = 1'b1;
                            cond_data = COND_ALLOC;
                            succ_next = al_rd;
                            if (head_reg == {1'b0, idx_reg}) begin
                                head_next = al_rd;
                                al_clr = 1'b1;
                            end else begin
                                cur_next = head_reg;
                                cnt_next = '0;
                                state_next = ST_UNLINK;
                            end
                        end
                    end
                    ACT_FIND: begin
                        cur_next = head_reg;
                        cnt_next = '0;
                        state_next = ST_FIND;
                    end
                    ACT_INIT: begin
                        init_en = 1'b1;
                        key_ctrl.clr_all = 1'b1;
                        free_top_next = LINK_W'(SLOT_COUNT - 1);
                        head_next = NULL_SLOT;
                    end
                    default: begin
                        status_next = STS_REFUSED;
                    end
                endcase
            end
            ST_FIND: begin
                if (cur_null) begin
                    status_next = STS_MISS;
                    state_next = ST_RESP;
                end else if (key_hit) begin
                    result_next = cur_idx;
                    state_next = ST_RESP;
                end else begin
                    cur_next = al_rd;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UNLINK: begin
                if (cur_null) begin
                    state_next = ST_RESP;
                end else if (al_rd == {1'b0, idx_reg}) begin
                    al_we = 1'b1;
                    al_addr = cur_idx;
                    al_data = succ_reg;
                    al_clr = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cur_next = al_rd;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_reg <= NULL_SLOT;
            cnt_reg <= '0;
            free_top_reg <= LINK_W'(SLOT_COUNT - 1);
            head_reg <= NULL_SLOT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cur_reg <= cur_next;
            cnt_reg <= cnt_next;
            free_top_reg <= free_top_next;
            head_reg <= head_next;
            if (state_reg == ST_RESP && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_tdata[2:0];
            idx_reg <= s_tdata[6:3];
            kh_reg <= s_tdata[70:7];
            kl_reg <= s_tdata[134:71] & LOW_KEY_MASK;
        end
        succ_reg <= succ_next;
        status_reg <= status_next;
        result_reg <= result_next;
        if (state_reg == ST_RESP && (!m_valid_reg || m_tready)) begin
            m_status_reg <= status_reg;
            m_result_reg <= (status_reg == STS_OK) ? result_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || init_en) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                free_link_reg[i] <= (i == 0) ? NULL_SLOT : LINK_W'(i - 1);
                active_link_reg[i] <= NULL_SLOT;
                cond_reg[i] <= COND_FREE;
            end
        end else begin
            if (fl_we) begin
                free_link_reg[fl_addr] <= fl_data;
            end
            if (al_clr) begin
                active_link_reg[idx_reg] <= NULL_SLOT;
            end
            if (al_we) begin
                active_link_reg[al_addr] <= al_data;
            end
            if (cond_we) begin
                cond_reg[cond_addr] <= cond_data;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {2'b00, m_result_reg, m_status_reg};

`ifndef SYNTHESIS
    a_top_is_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_top_reg < LINK_W'(SLOT_COUNT)) |-> (cond_reg[top_idx] == COND_FREE))
        else $error("free stack top is not a free slot");

    a_head_is_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg < LINK_W'(SLOT_COUNT)) |-> (cond_reg[head_reg[SLOT_W-1:0]] == COND_ACTIVE))
        else $error("active list head is not an active slot");

    a_walk_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LINK_W'(SLOT_COUNT))
        else $error("list walk ran past the pool size");

    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STS_OK) |-> (m_result_reg == '0))
        else $error("nonzero index with a failing status");
`endif

endmodule

FILE: bench/transaction_slot_pool_lookup_check.sv
module transaction_slot_pool_lookup_check
    import tspl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] index;
    } outcome_t;

    logic [KEY_W-1:0]  id_hi [SLOT_COUNT];
    logic [KEY_W-1:0]  id_lo [SLOT_COUNT];
    logic [LINK_W-1:0] free_next [SLOT_COUNT];
    logic [LINK_W-1:0] chain_next [SLOT_COUNT];
    logic [1:0]        slot_state [SLOT_COUNT];
    logic [LINK_W-1:0] free_head;
    logic [LINK_W-1:0] chain_head;

    outcome_t awaited_results [$];
    int       error_count = 0;

    function automatic void clear_pool();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            id_hi[i] = '0;
            id_lo[i] = '0;
            free_next[i] = (i == 0) ? NULL_SLOT : LINK_W'(i - 1);
            chain_next[i] = NULL_SLOT;
            slot_state[i] = COND_FREE;
        end
        free_head = LINK_W'(SLOT_COUNT - 1);
        chain_head = NULL_SLOT;
    endfunction

    function automatic outcome_t apply_action(logic [2:0] act, logic [SLOT_W-1:0] idx,
                                              logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl_raw);
        outcome_t          res;
        logic [KEY_W-1:0]  kl;
        logic [SLOT_W-1:0] s;
        logic [LINK_W-1:0] cur;
        bit                idx_ok;
        bit                done;
        kl = kl_raw & LOW_KEY_MASK;
        res.status = STS_OK;
        res.index = '0;
        s = idx;
        idx_ok = int'(idx) < SLOT_COUNT;
        done = 1'b0;
        case (act)
            ACT_ALLOC: begin
                if (free_head >= SLOT_COUNT) begin
                    res.status = STS_MISS;
                end else begin
                    s = free_head[SLOT_W-1:0];
                    free_head = free_next[s];
                    free_next[s] = NULL_SLOT;
                    slot_state[s] = COND_ALLOC;
                    res.index = s;
                end
            end
            ACT_FREE: begin
                if (!idx_ok || slot_state[s] != COND_ALLOC) begin
                    res.status = STS_REFUSED;
                end else begin
                    id_hi[s] = '0;
                    id_lo[s] = '0;
                    chain_next[s] = NULL_SLOT;
                    free_next[s] = free_head;
                    free_head = LINK_W'(s);
                    slot_state[s] = COND_FREE;
                end
            end
            ACT_INSERT: begin
                if (!idx_ok || slot_state[s] != COND_ALLOC) begin
                    res.status = STS_REFUSED;
                end else begin
                    id_hi[s] = kh;
                    id_lo[s] = kl;
                    chain_next[s] = chain_head;
                    chain_head = LINK_W'(s);
                    slot_state[s] = COND_ACTIVE;
                end
            end
            ACT_REMOVE: begin
                if (!idx_ok || slot_state[s] != COND_ACTIVE) begin
                    res.status = STS_REFUSED;
                end else begin
                    if (chain_head == LINK_W'(s)) begin
                        chain_head = chain_next[s];
                        chain_next[s] = NULL_SLOT;
                    end else begin
                        cur = chain_head;
                        for (int n = 0; n < SLOT_COUNT && cur < SLOT_COUNT && !done; n++) begin
                            if (chain_next[cur[SLOT_W-1:0]] == LINK_W'(s)) begin
                                chain_next[cur[SLOT_W-1:0]] = chain_next[s];
                                chain_next[s] = NULL_SLOT;
                                done = 1'b1;
                            end else begin
                                cur = chain_next[cur[SLOT_W-1:0]];
                            end
                        end
                    end
                    slot_state[s] = COND_ALLOC;
                end
            end
            ACT_FIND: begin
                res.status = STS_MISS;
                cur = chain_head;
                for (int n = 0; n < SLOT_COUNT && cur < SLOT_COUNT && !done; n++) begin
                    if (id_hi[cur[SLOT_W-1:0]] == kh
                            && (id_lo[cur[SLOT_W-1:0]] & LOW_KEY_MASK) == kl) begin
                        res.status = STS_OK;
                        res.index = cur[SLOT_W-1:0];
                        done = 1'b1;
                    end else begin
                        cur = chain_next[cur[SLOT_W-1:0]];
                    end
                end
            end
            ACT_INIT: begin
                clear_pool();
            end
            default: begin
                res.status = STS_REFUSED;
            end
        endcase
        if (res.status != STS_OK) begin
            res.index = '0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            clear_pool();
            awaited_results.delete();
        end else begin
            // The oldest waiting word is compared before this edge's input word is predicted.
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result word with nothing expected, got status %0d index %0d",
                             $time, m_tdata[1:0], m_tdata[5:2]);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, m_tdata[1:0]);
                        error_count++;
                    end
                    if (m_tdata[5:2] !== want.index) begin
                        $display("%0t: result_index mismatch, expected %0d, got %0d",
                                 $time, want.index, m_tdata[5:2]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_action(s_tdata[2:0], s_tdata[6:3],
                                                       s_tdata[70:7], s_tdata[134:71]));
            end
        end
        errors <= error_count;
        pending <= awaited_results.size();
    end

endmodule

FILE: bench/transaction_slot_pool_lookup_top_tb.sv
module transaction_slot_pool_lookup_top_tb;
    import tspl_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 25;
    localparam int RANDOM_WORDS = 360;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;

    int           errors;
    int           pending;
    int           quiet_cycles = 0;
    bit           calm = 1'b0;
    bit           rx_hold = 1'b0;
    bit           hold_req = 1'b0;
    logic [127:0] id_pool [6];

    always #1 aclk = ~aclk;

    transaction_slot_pool_lookup_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    transaction_slot_pool_lookup_check u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always @(negedge aclk) begin
        m_tready <= rx_hold ? 1'b0 : (calm || $urandom_range(99) >= 11);
    end

    initial begin
        @(posedge hold_req);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        rx_hold = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(input logic [2:0] act, input logic [3:0] idx,
                             input logic [63:0] kh, input logic [63:0] kl);
        int gap;
        gap = (!calm && $urandom_range(99) < 11) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, kl, kh, idx, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        logic [2:0]   act;
        logic [127:0] id;
        int           r;
        id_pool[0] = '1;
        id_pool[1] = '0;
        for (int i = 2; i < 6; i++) begin
            id_pool[i] = {$urandom, $urandom, $urandom, $urandom};
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_word(ACT_FIND, 4'd0, '1, '1);
        send_word(ACT_SPARE_LO, 4'd0, '0, '0);
        send_word(ACT_SPARE_HI, 4'd15, '1, '1);
        send_word(ACT_FREE, 4'd0, '0, '0);
        send_word(ACT_INSERT, 4'd0, '1, '1);
        send_word(ACT_REMOVE, 4'd0, '0, '0);
        send_word(ACT_ALLOC, 4'd0, '0, '0);
        send_word(ACT_INSERT, 4'd15, '1, '1);
        send_word(ACT_INSERT, 4'd15, '0, '0);
        send_word(ACT_FREE, 4'd15, '0, '0);
        send_word(ACT_ALLOC, 4'd0, '0, '0);
        send_word(ACT_INSERT, 4'd14, '1, '1);
        send_word(ACT_FIND, 4'd0, '1, '1);
        send_word(ACT_REMOVE, 4'd15, '0, '0);
        send_word(ACT_REMOVE, 4'd15, '0, '0);
        send_word(ACT_FIND, 4'd0, '1, '1);
        send_word(ACT_FIND, 4'd0, '0, '0);
        send_word(ACT_REMOVE, 4'd14, '0, '0);
        send_word(ACT_FREE, 4'd14, '0, '0);
        send_word(ACT_FREE, 4'd15, '0, '0);
        send_word(ACT_INIT, 4'd0, '0, '0);
        send_word(ACT_FIND, 4'd0, '1, '1);
        drain_results();

        // The receiver stalls as the whole pool is taken, one allocation past it misses, and every slot is inserted.
        hold_req = 1'b1;
        calm = 1'b1;
        for (int i = 0; i <= SLOT_COUNT; i++) begin
            send_word(ACT_ALLOC, 4'($urandom_range(15)), '0, '0);
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            id = id_pool[$urandom_range(5)];
            send_word(ACT_INSERT, 4'(i), id[127:64], id[63:0]);
        end
        calm = 1'b0;
        drain_results();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= 150 && i < 230);
            r = $urandom_range(99);
            if (r < 24) begin
                act = ACT_ALLOC;
            end else if (r < 36) begin
                act = ACT_FREE;
            end else if (r < 58) begin
                act = ACT_INSERT;
            end else if (r < 70) begin
                act = ACT_REMOVE;
            end else if (r < 93) begin
                act = ACT_FIND;
            end else if (r < 95) begin
                act = ACT_INIT;
            end else begin
                act = ($urandom_range(1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
            end
            if ($urandom_range(99) < 80) begin
                id = id_pool[$urandom_range(5)];
            end else begin
                id = {$urandom, $urandom, $urandom, $urandom};
            end
            send_word(act, 4'($urandom_range(15)), id[127:64], id[63:0]);
        end
        calm = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tspl_pkg.sv
hw/rtl/tspl_key_store.sv
hw/rtl/transaction_slot_pool_lookup_top.sv
bench/transaction_slot_pool_lookup_check.sv
bench/transaction_slot_pool_lookup_top_tb.sv
